// ===== rtl/ntc_table_temperature_lookup_assert.svh =====
// Assertion macros shared by the NTC temperature lookup modules.
`ifndef NTC_TABLE_TEMPERATURE_LOOKUP_ASSERT_SVH
`define NTC_TABLE_TEMPERATURE_LOOKUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NTC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define NTC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NTC_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define NTC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/ntc_pkg.sv =====
// Package with the sizes, calibration table and shared types of the NTC lookup.
`timescale 1ns / 1ps
package ntc_pkg;

    localparam int TABLE_ENTRIES  = 91;
    localparam int SAMPLE_BITS    = 12;
    localparam int ROM_BITS       = 12;
    localparam int CAL_ENTRIES    = 91;
    localparam int CAL_IDX_BITS   = 7;
    localparam int SLOT_BITS      = 8;
    localparam int WORD_BITS      = (SAMPLE_BITS > ROM_BITS) ? SAMPLE_BITS : ROM_BITS;
    localparam int CMP_BITS       = WORD_BITS + 1;
    localparam int IDX_BITS       = $clog2(TABLE_ENTRIES + 1);
    localparam int ROUNDS         = TABLE_ENTRIES / 2;
    localparam int RND_BITS       = $clog2(ROUNDS + 1);
    localparam int TOL_BITS       = 12;
    localparam int MAXT_BITS      = 7;
    localparam int TEMP_BITS      = 8;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 12;
    localparam int TEMP_CALC_BITS = ((MAXT_BITS > IDX_BITS) ? MAXT_BITS : IDX_BITS) + 2;
    localparam int TEMP_MIN       = -128;

    localparam logic [TOL_BITS-1:0]  TOL_RESET  = TOL_BITS'(10);
    localparam logic [MAXT_BITS-1:0] MAXT_RESET = MAXT_BITS'(100);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_TOLERANCE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_TEMPERATURE = CFG_IDX_BITS'(1);

    // Ascending ADC codes from 100 degrees down to 10 degrees in one-degree steps.
    localparam logic [ROM_BITS-1:0] CAL_ROM [0:CAL_ENTRIES-1] = '{
        12'd590,  12'd604,  12'd619,  12'd634,  12'd649,  12'd665,  12'd681,
        12'd698,  12'd715,  12'd732,  12'd750,  12'd768,  12'd787,  12'd806,
        12'd825,  12'd845,  12'd866,  12'd887,  12'd908,  12'd930,  12'd953,
        12'd975,  12'd999,  12'd1023, 12'd1047, 12'd1072, 12'd1097, 12'd1123,
        12'd1150, 12'd1177, 12'd1204, 12'd1232, 12'd1261, 12'd1290, 12'd1319,
        12'd1349, 12'd1380, 12'd1411, 12'd1442, 12'd1474, 12'd1507, 12'd1540,
        12'd1573, 12'd1607, 12'd1642, 12'd1676, 12'd1712, 12'd1747, 12'd1783,
        12'd1820, 12'd1856, 12'd1893, 12'd1931, 12'd1968, 12'd2006, 12'd2044,
        12'd2083, 12'd2121, 12'd2160, 12'd2199, 12'd2238, 12'd2277, 12'd2316,
        12'd2355, 12'd2394, 12'd2434, 12'd2473, 12'd2512, 12'd2550, 12'd2589,
        12'd2627, 12'd2666, 12'd2704, 12'd2741, 12'd2779, 12'd2816, 12'd2853,
        12'd2889, 12'd2925, 12'd2960, 12'd2996, 12'd3030, 12'd3064, 12'd3098,
        12'd3131, 12'd3163, 12'd3195, 12'd3226, 12'd3257, 12'd3287, 12'd3316
    };

    // Entries past the calibrated range read as zero.
    function automatic logic [WORD_BITS-1:0] rom_value(input logic [IDX_BITS-1:0] idx);
        logic [SLOT_BITS-1:0] slot;
        logic [WORD_BITS-1:0] value;
        slot  = SLOT_BITS'(idx);
        value = '0;
        if (slot < SLOT_BITS'(CAL_ENTRIES)) begin
            value = WORD_BITS'(CAL_ROM[slot[CAL_IDX_BITS-1:0]]);
        end
        return value;
    endfunction

    localparam logic [WORD_BITS-1:0] ROM_FIRST = rom_value(IDX_BITS'(0));
    localparam logic [WORD_BITS-1:0] ROM_LAST  = rom_value(IDX_BITS'(TABLE_ENTRIES - 1));

    typedef struct packed {
        logic busy;
        logic done;
    } srch_status_t;

endpackage

// ===== rtl/ntc_search.sv =====
// Bisection search over the calibration table with a shared compare and score unit.
`timescale 1ns / 1ps
`include "ntc_table_temperature_lookup_assert.svh"
module ntc_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [ntc_pkg::WORD_BITS-1:0]       target,
    input  logic [ntc_pkg::TOL_BITS-1:0]        tolerance,
    output ntc_pkg::srch_status_t               status,
    output logic [ntc_pkg::IDX_BITS-1:0]        index
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } srch_state_t;

    srch_state_t                      state_reg, state_next;
    logic [ntc_pkg::IDX_BITS-1:0]     probe_reg, probe_next;
    logic [ntc_pkg::IDX_BITS-1:0]     low_reg, low_next;
    logic [ntc_pkg::IDX_BITS-1:0]     high_reg, high_next;
    logic [ntc_pkg::IDX_BITS-1:0]     best_reg, best_next;
    logic [ntc_pkg::CMP_BITS-1:0]     best_diff_reg, best_diff_next;
    logic [ntc_pkg::RND_BITS-1:0]     round_reg, round_next;
    logic [ntc_pkg::WORD_BITS-1:0]    target_reg, target_next;
    logic                             done_reg, done_next;
    logic [ntc_pkg::IDX_BITS-1:0]     index_reg, index_next;

    logic [ntc_pkg::WORD_BITS-1:0]    probe_val;
    logic [ntc_pkg::WORD_BITS-1:0]    diff;
    logic                             scored;
    logic                             better;
    logic [ntc_pkg::CMP_BITS-1:0]     cand_diff;
    logic [ntc_pkg::IDX_BITS-1:0]     cand_best;
    logic                             tol_hit;
    logic [ntc_pkg::IDX_BITS-1:0]     step_probe, step_low, step_high;
    logic                             fixed_point;

    // Shared unit: one table read, one difference, one score and one bound step.
    always_comb begin
        probe_val = ntc_pkg::rom_value(probe_reg);
        diff      = (probe_val > target_reg) ? (probe_val - target_reg)
                                             : (target_reg - probe_val);
        // The opening probe only seeds the best index and is not scored.
        scored    = (round_reg != '0);
        better    = scored && ({1'b0, diff} < best_diff_reg);
        cand_diff = better ? {1'b0, diff} : best_diff_reg;
        cand_best = better ? probe_reg : best_reg;
        tol_hit   = scored && (cand_diff <= ntc_pkg::CMP_BITS'(tolerance));
        if (probe_val > target_reg) begin
            step_low   = low_reg;
            step_high  = probe_reg;
            step_probe = low_reg + ((probe_reg - low_reg) >> 1);
        end else begin
            step_low   = probe_reg;
            step_high  = high_reg;
            step_probe = probe_reg + ((high_reg - probe_reg) >> 1);
        end
        fixed_point = (step_probe == probe_reg) && (step_low == low_reg)
                   && (step_high == high_reg);
    end

    always_comb begin
        state_next     = state_reg;
        probe_next     = probe_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        best_next      = best_reg;
        best_diff_next = best_diff_reg;
        round_next     = round_reg;
        target_next    = target_reg;
        done_next      = 1'b0;
        index_next     = index_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next     = S_RUN;
                    probe_next     = ntc_pkg::IDX_BITS'(ntc_pkg::TABLE_ENTRIES / 2);
                    best_next      = ntc_pkg::IDX_BITS'(ntc_pkg::TABLE_ENTRIES / 2);
                    low_next       = '0;
                    high_next      = ntc_pkg::IDX_BITS'(ntc_pkg::TABLE_ENTRIES);
                    best_diff_next = '1;
                    round_next     = '0;
                    target_next    = target;
                end
            end
            S_RUN: begin
                best_next      = cand_best;
                best_diff_next = cand_diff;
                if (tol_hit || (round_reg == ntc_pkg::RND_BITS'(ntc_pkg::ROUNDS))) begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    index_next = cand_best;
                end else if (probe_val == target_reg) begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    index_next = probe_reg;
                end else if (fixed_point) begin
                    // Later rounds would rescore the same probe and change nothing.
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    index_next = cand_best;
                end else begin
                    probe_next = step_probe;
                    low_next   = step_low;
                    high_next  = step_high;
                    round_next = round_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge aclk) begin
        probe_reg     <= probe_next;
        low_reg       <= low_next;
        high_reg      <= high_next;
        best_reg      <= best_next;
        best_diff_reg <= best_diff_next;
        target_reg    <= target_next;
        index_reg     <= index_next;
    end

    assign status.busy = (state_reg == S_RUN);
    assign status.done = done_reg;
    assign index       = index_reg;

    `NTC_ASSERT_SAME(a_start_idle, aclk, aresetn, start, state_reg == S_IDLE, "search started while busy")
    `NTC_ASSERT_SAME(a_probe_in_bounds, aclk, aresetn, state_reg == S_RUN, (low_reg <= probe_reg) && (probe_reg <= high_reg), "probe outside bounds")
    `NTC_ASSERT_SAME(a_round_limit, aclk, aresetn, state_reg == S_RUN, round_reg <= ntc_pkg::RND_BITS'(ntc_pkg::ROUNDS), "round count past limit")
    `NTC_ASSERT_SAME(a_index_range, aclk, aresetn, done_reg, index_reg < ntc_pkg::IDX_BITS'(ntc_pkg::TABLE_ENTRIES), "index beyond table")

endmodule

// ===== rtl/ntc_table_temperature_lookup.sv =====
// A repeated reading goes from the idle state through the finish state to the output register;
// a fresh one first passes through the search state, where the bisection search runs to its end.
// Throughput: one request at a time; the next is taken once the result is loaded into
// the output register, and a result waits in the finish state while that register is full.
// Reset (aresetn, synchronous, active low) clears the handshake state, sets the tolerance
// to 10 and the top temperature to 100, and clears the last temperature to zero.
`timescale 1ns / 1ps
`include "ntc_table_temperature_lookup_assert.svh"
module ntc_table_temperature_lookup (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [ntc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [ntc_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_conversion_done,
    input  logic [11:0]                            s_adc_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [ntc_pkg::TEMP_BITS-1:0]   m_temperature_deg,
    output logic                                   m_fresh_value
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FINISH = 3'b100
    } top_state_t;

    top_state_t                          state_reg, state_next;
    logic [ntc_pkg::TOL_BITS-1:0]        tol_reg;
    logic [ntc_pkg::MAXT_BITS-1:0]       max_temp_reg;
    logic [ntc_pkg::TEMP_BITS-1:0]       last_temp_reg, last_temp_next;
    logic [ntc_pkg::TEMP_BITS-1:0]       res_temp_reg, res_temp_next;
    logic                                res_fresh_reg, res_fresh_next;
    logic                                m_valid_reg, m_valid_next;
    logic [ntc_pkg::TEMP_BITS-1:0]       m_temp_reg, m_temp_next;
    logic                                m_fresh_reg, m_fresh_next;

    logic                                in_accept;
    logic                                srch_start;
    logic [ntc_pkg::WORD_BITS-1:0]       sample;
    logic [ntc_pkg::WORD_BITS-1:0]       target;
    ntc_pkg::srch_status_t               srch_status;
    logic [ntc_pkg::IDX_BITS-1:0]        srch_index;
    logic signed [ntc_pkg::TEMP_CALC_BITS-1:0] temp_wide;
    logic [ntc_pkg::TEMP_BITS-1:0]       temp_sat;

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_accept  = s_valid && s_ready;
    assign srch_start = in_accept && s_conversion_done;

    // Clamp the sample to the ends of the calibrated range.
    always_comb begin
        sample = ntc_pkg::WORD_BITS'(s_adc_sample[ntc_pkg::SAMPLE_BITS-1:0]);
        if (sample < ntc_pkg::ROM_FIRST) begin
            target = ntc_pkg::ROM_FIRST;
        end else if (sample > ntc_pkg::ROM_LAST) begin
            target = ntc_pkg::ROM_LAST;
        end else begin
            target = sample;
        end
    end

    ntc_search u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (srch_start),
        .target    (target),
        .tolerance (tol_reg),
        .status    (srch_status),
        .index     (srch_index)
    );

    // Temperature is the top value minus the index, saturated at the negative limit.
    always_comb begin
        temp_wide = $signed(ntc_pkg::TEMP_CALC_BITS'(max_temp_reg))
                  - $signed(ntc_pkg::TEMP_CALC_BITS'(srch_index));
        if (temp_wide < ntc_pkg::TEMP_CALC_BITS'(ntc_pkg::TEMP_MIN)) begin
            temp_sat = ntc_pkg::TEMP_BITS'(ntc_pkg::TEMP_MIN);
        end else begin
            temp_sat = temp_wide[ntc_pkg::TEMP_BITS-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        last_temp_next = last_temp_reg;
        res_temp_next  = res_temp_reg;
        res_fresh_next = res_fresh_reg;
        m_valid_next   = m_valid_reg;
        m_temp_next    = m_temp_reg;
        m_fresh_next   = m_fresh_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_conversion_done) begin
                        state_next = ST_SEARCH;
                    end else begin
                        state_next     = ST_FINISH;
                        res_temp_next  = last_temp_reg;
                        res_fresh_next = 1'b0;
                    end
                end
            end
            ST_SEARCH: begin
                if (srch_status.done) begin
                    state_next     = ST_FINISH;
                    res_temp_next  = temp_sat;
                    res_fresh_next = 1'b1;
                    last_temp_next = temp_sat;
                end
            end
            ST_FINISH: begin
                // The result waits here until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_temp_next  = res_temp_reg;
                    m_fresh_next = res_fresh_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            last_temp_reg <= '0;
            tol_reg       <= ntc_pkg::TOL_RESET;
            max_temp_reg  <= ntc_pkg::MAXT_RESET;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            last_temp_reg <= last_temp_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    ntc_pkg::CFG_MATCH_TOLERANCE: begin
                        tol_reg <= cfg_wdata[ntc_pkg::TOL_BITS-1:0];
                    end
                    ntc_pkg::CFG_MAX_TEMPERATURE: begin
                        max_temp_reg <= cfg_wdata[ntc_pkg::MAXT_BITS-1:0];
                    end
                    default: begin
                        tol_reg <= tol_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_temp_reg  <= res_temp_next;
        res_fresh_reg <= res_fresh_next;
        m_temp_reg    <= m_temp_next;
        m_fresh_reg   <= m_fresh_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_temperature_deg = $signed(m_temp_reg);
    assign m_fresh_value     = m_fresh_reg;

    `NTC_ASSERT_NEXT(a_single_request, aclk, aresetn, in_accept, !s_ready, "request taken while busy")
    `NTC_ASSERT_SAME(a_done_in_search, aclk, aresetn, srch_status.done, state_reg == ST_SEARCH, "search result outside search state")
    `NTC_ASSERT_SAME(a_busy_in_search, aclk, aresetn, srch_status.busy, state_reg == ST_SEARCH, "search running outside search state")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the NTC thermistor table temperature lookup.
`timescale 1ns / 1ps
module testbench;

    typedef struct packed {
        logic signed [7:0] temp;
        logic              fresh;
    } reading_t;

    typedef struct packed {
        logic        done;
        logic [11:0] sample;
        logic        typed;
        logic [7:0]  temp;
        logic        fresh;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam int PHASES = 8;
    localparam int PHASE_READINGS = 230;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 60;

    // Known answers come first; the remaining rows are left to the predictor.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, 12'h000, 1'b1, 8'd0,   1'b0},
        '{1'b1, 12'h000, 1'b1, 8'd100, 1'b1},
        '{1'b0, 12'hFFF, 1'b1, 8'd100, 1'b0},
        '{1'b1, 12'd589, 1'b1, 8'd100, 1'b1},
        '{1'b1, 12'd590, 1'b1, 8'd100, 1'b1},
        '{1'b1, 12'hFFF, 1'b1, 8'd10,  1'b1},
        '{1'b1, 12'd3316, 1'b1, 8'd10, 1'b1},
        '{1'b1, 12'd3317, 1'b1, 8'd10, 1'b1},
        '{1'b1, 12'd1676, 1'b1, 8'd55, 1'b1},
        '{1'b0, 12'd1676, 1'b1, 8'd55, 1'b0},
        '{1'b1, 12'd604,  1'b0, 8'd0, 1'b0},
        '{1'b1, 12'd3287, 1'b0, 8'd0, 1'b0},
        '{1'b1, 12'd999,  1'b0, 8'd0, 1'b0},
        '{1'b1, 12'd1000, 1'b0, 8'd0, 1'b0},
        '{1'b1, 12'd1010, 1'b0, 8'd0, 1'b0},
        '{1'b1, 12'd1011, 1'b0, 8'd0, 1'b0},
        '{1'b1, 12'd2000, 1'b0, 8'd0, 1'b0},
        '{1'b1, 12'h555,  1'b0, 8'd0, 1'b0},
        '{1'b1, 12'hAAA,  1'b0, 8'd0, 1'b0},
        '{1'b0, 12'hAAA,  1'b0, 8'd0, 1'b0},
        '{1'b1, 12'h7FF,  1'b0, 8'd0, 1'b0},
        '{1'b1, 12'h800,  1'b0, 8'd0, 1'b0},
        '{1'b1, 12'd1300, 1'b0, 8'd0, 1'b0},
        '{1'b1, 12'd3000, 1'b0, 8'd0, 1'b0}
    };

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_wr_en;
    logic [ntc_pkg::CFG_IDX_BITS-1:0]   cfg_index;
    logic [ntc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;
    logic                               s_valid;
    logic                               s_ready;
    logic                               s_conversion_done;
    logic [11:0]                        s_adc_sample;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [ntc_pkg::TEMP_BITS-1:0] m_temperature_deg;
    logic                               m_fresh_value;

    // Predictor state and its copy of the registers.
    logic [11:0]       tolerance_now;
    logic [6:0]        top_temp_now;
    logic signed [7:0] held_temp;

    reading_t expected_readings [$];
    int       mismatches;
    bit       steady;
    bit       hold_pending;
    int       hold_left;

    ntc_table_temperature_lookup uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_conversion_done (s_conversion_done),
        .s_adc_sample      (s_adc_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_temperature_deg (m_temperature_deg),
        .m_fresh_value     (m_fresh_value)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Bisection of the calibration table, keeping the closest probe seen so far.
    function automatic logic [7:0] nearest_table_index(input logic [11:0] target,
                                                        input logic [11:0] tol);
        logic [7:0]  probe;
        logic [7:0]  best;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [12:0] best_diff;
        logic [12:0] diff;
        logic [11:0] entry;
        probe = 8'(ntc_pkg::TABLE_ENTRIES / 2);
        best = probe;
        lo = 8'd0;
        hi = 8'(ntc_pkg::TABLE_ENTRIES);
        best_diff = '1;
        for (int r = 0; r < ntc_pkg::TABLE_ENTRIES / 2; r++) begin
            entry = ntc_pkg::CAL_ROM[probe];
            if (entry == target) begin
                return probe;
            end
            if (entry > target) begin
                hi = probe;
                probe = lo + (hi - lo) / 2;
            end else begin
                lo = probe;
                probe = probe + (hi - lo) / 2;
            end
            entry = ntc_pkg::CAL_ROM[probe];
            diff = (entry > target) ? 13'(entry - target) : 13'(target - entry);
            if (diff < best_diff) begin
                best = probe;
                best_diff = diff;
            end
            if (best_diff <= 13'(tol)) begin
                return best;
            end
        end
        return best;
    endfunction

    task automatic predict_reading(input logic done, input logic [11:0] sample,
                                   output reading_t result);
        logic [11:0]       clamped;
        logic [7:0]        idx;
        logic signed [9:0] degrees;
        if (!done) begin
            result = '{held_temp, 1'b0};
        end else begin
            clamped = sample;
            if (clamped < ntc_pkg::CAL_ROM[0]) begin
                clamped = ntc_pkg::CAL_ROM[0];
            end
            if (clamped > ntc_pkg::CAL_ROM[ntc_pkg::TABLE_ENTRIES-1]) begin
                clamped = ntc_pkg::CAL_ROM[ntc_pkg::TABLE_ENTRIES-1];
            end
            idx = nearest_table_index(clamped, tolerance_now);
            degrees = $signed({3'b000, top_temp_now}) - $signed({2'b00, idx});
            if (degrees < -10'sd128) begin
                degrees = -10'sd128;
            end
            held_temp = degrees[7:0];
            result = '{held_temp, 1'b1};
        end
    endtask

    // Offers one poll request; returns at the edge that accepts it.
    task automatic offer_reading(input logic done, input logic [11:0] sample,
                                 input logic typed, input logic [7:0] typed_temp,
                                 input logic typed_fresh);
        reading_t result;
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_conversion_done <= done;
        s_adc_sample <= sample;
        do @(posedge aclk); while (!s_ready);
        predict_reading(done, sample, result);
        if (typed) begin
            result = '{typed_temp, typed_fresh};
        end
        expected_readings.push_back(result);
    endtask

    task automatic wait_for_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic apply_settings(input logic [11:0] tol, input logic [6:0] top_temp);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= ntc_pkg::CFG_MATCH_TOLERANCE;
        cfg_wdata <= tol;
        @(negedge aclk);
        cfg_index <= ntc_pkg::CFG_MAX_TEMPERATURE;
        cfg_wdata <= ntc_pkg::CFG_DATA_BITS'(top_temp);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tolerance_now = tol;
        top_temp_now = top_temp;
    endtask

    // Samples lean towards table entries and their neighbourhoods, where ties and
    // early stops happen.
    function automatic logic [11:0] pick_sample();
        int value;
        case ($urandom_range(3))
            0: value = $urandom_range(4095);
            1: value = $urandom_range(3316, 590);
            2: value = ntc_pkg::CAL_ROM[$urandom_range(ntc_pkg::TABLE_ENTRIES - 1)];
            default: begin
                value = int'(ntc_pkg::CAL_ROM[$urandom_range(ntc_pkg::TABLE_ENTRIES - 1)])
                        + $urandom_range(40) - 20;
            end
        endcase
        if (value < 0) begin
            value = 0;
        end
        if (value > 4095) begin
            value = 4095;
        end
        return 12'(value);
    endfunction

    initial begin
        m_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 30);
            end
        end
    end

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                $error("result with no request outstanding: temperature_deg %0d fresh_value %0b",
                       m_temperature_deg, m_fresh_value);
                mismatches++;
            end else begin
                want = expected_readings.pop_front();
                if (m_temperature_deg !== want.temp) begin
                    $error("temperature_deg: expected %0d, actual %0d",
                           want.temp, m_temperature_deg);
                    mismatches++;
                end
                if (m_fresh_value !== want.fresh) begin
                    $error("fresh_value: expected %0b, actual %0b", want.fresh, m_fresh_value);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        logic [11:0] phase_tol [PHASES];
        logic [6:0]  phase_top [PHASES];
        logic        done;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = ntc_pkg::CFG_MATCH_TOLERANCE;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_conversion_done = 1'b0;
        s_adc_sample = '0;
        mismatches = 0;
        steady = 1'b0;
        hold_pending = 1'b0;
        tolerance_now = 12'd10;
        top_temp_now = 7'd100;
        held_temp = '0;
        phase_tol = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd10, 12'd0, 12'd0, 12'd0};
        phase_top = '{7'd127, 7'd0, 7'd0, 7'd127, 7'd100, 7'd0, 7'd0, 7'd0};
        for (int p = 5; p < PHASES; p++) begin
            phase_tol[p] = 12'($urandom_range(60));
            phase_top[p] = 7'($urandom_range(127));
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            offer_reading(DIRECTED[i].done, DIRECTED[i].sample, DIRECTED[i].typed,
                          DIRECTED[i].temp, DIRECTED[i].fresh);
        end
        wait_for_idle();

        for (int p = 0; p < PHASES; p++) begin
            apply_settings(phase_tol[p], phase_top[p]);
            steady = (p == 2);
            // The receiver holds off long enough for the block to stall its input.
            if (p == 3) begin
                hold_pending = 1'b1;
            end
            repeat (PHASE_READINGS) begin
                done = ($urandom_range(99) < 80);
                offer_reading(done, pick_sample(), 1'b0, 8'd0, 1'b0);
            end
            wait_for_idle();
        end
        steady = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_readings.size() != 0) begin
            $error("%0d results never arrived", expected_readings.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ntc_pkg.sv
rtl/ntc_search.sv
rtl/ntc_table_temperature_lookup.sv
dv/testbench.sv
